// ===== hdl/cff_pkg.sv =====
package cff_pkg;

  localparam int PIEZO_ELEMENTS = 64;
  localparam int CAP_ELEMENTS   = 32;
  localparam int PI_AW          = $clog2(PIEZO_ELEMENTS);
  localparam int CI_AW          = $clog2(CAP_ELEMENTS);
  localparam int FORCE_W        = 32;

  localparam int PIEZO_K        = 28836;
  localparam int PIEZO_SHIFT    = 20;
  localparam int CAP_K          = 512000;
  localparam int CAP_SHIFT      = 24;
  localparam int COEFF_SHIFT    = 24;
  localparam int FORCE_LIMIT_Q8 = 32000 * 256;
  localparam int FORCE_LIMIT    = 32000;

  localparam logic [23:0] HP_RESET = 24'd16766680;
  localparam logic [23:0] LP_RESET = 24'd4010700;

  localparam logic REG_HP_COEFF = 1'b0;
  localparam logic REG_LP_COEFF = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_SUM,
    ST_MUL2,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic mul1;
    logic sum;
    logic mul2;
    logic fin;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic out_blocked;
  } status_t;

  // round to nearest, halves away from zero
  function automatic logic signed [63:0] round_sh(input logic signed [63:0] v, input int n);
    logic [63:0] mag;
    logic [63:0] r;
    mag = v[63] ? 64'(-v) : 64'(v);
    r   = (mag + (64'd1 << (n - 1))) >> n;
    return v[63] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

// ===== hdl/cff_ram.sv =====
module cff_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// ===== hdl/cff_ctrl.sv =====
module cff_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  cff_pkg::status_t status,
  output cff_pkg::cmd_t    cmd
);

  cff_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= cff_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      cff_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = cff_pkg::ST_MUL1;
        end
      end
      cff_pkg::ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = cff_pkg::ST_SUM;
      end
      cff_pkg::ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = cff_pkg::ST_MUL2;
      end
      cff_pkg::ST_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = cff_pkg::ST_FIN;
      end
      cff_pkg::ST_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = cff_pkg::ST_OUT;
      end
      cff_pkg::ST_OUT: begin
        // wait until the output register can take the result
        if (!status.out_blocked) begin
          cmd.out_load = 1'b1;
          state_nxt    = cff_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cff_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/cff_dp.sv =====
module cff_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  cff_pkg::cmd_t       cmd,
  output cff_pkg::status_t    status,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [23:0]         cfg_data,
  input  logic [5:0]          in_element,
  input  logic signed [11:0]  in_piezo_count,
  input  logic signed [23:0]  in_cap_code,
  input  logic [15:0]         in_piezo_gain,
  input  logic [15:0]         in_cap_gain,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [5:0]          out_element,
  output logic signed [15:0]  out_force,
  output logic                out_clipped
);

  localparam int PI_AW = cff_pkg::PI_AW;
  localparam int CI_AW = cff_pkg::CI_AW;

  logic [23:0] hp_coeff_r, lp_coeff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hp_coeff_r <= cff_pkg::HP_RESET;
      lp_coeff_r <= cff_pkg::LP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cff_pkg::REG_HP_COEFF: hp_coeff_r <= cfg_data;
        cff_pkg::REG_LP_COEFF: lp_coeff_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [5:0]        elem_r;
  logic              code_nz_r;
  logic signed [28:0] m1_r;
  logic signed [40:0] cm1_r;
  logic signed [43:0] pprod_r;
  logic signed [60:0] cprod_r;
  logic signed [31:0] p_r, capf_r, lpold_r;
  logic signed [33:0] hpsum_r;
  logic signed [32:0] diff_r;
  logic signed [58:0] hprod_r;
  logic signed [57:0] lprod_r;
  logic signed [31:0] hpf_r, lpf_r;
  logic pv_hit_r, held_hit_r, lp_hit_r;

  // entries never written read as zero
  logic [cff_pkg::PIEZO_ELEMENTS-1:0] pv_vld_r, held_vld_r;
  logic [cff_pkg::CAP_ELEMENTS-1:0]   lp_vld_r;

  logic [PI_AW-1:0] rd_pi, pi;
  logic [CI_AW-1:0] rd_ci, ci;
  assign rd_pi = in_element[PI_AW-1:0];
  assign rd_ci = in_element[CI_AW:1];
  assign pi    = elem_r[PI_AW-1:0];
  assign ci    = elem_r[CI_AW:1];

  logic [31:0] hp_rd, prev_rd, held_rd, lp_rd;
  logic signed [31:0] hp_res, lp_res;

  cff_ram #(.WIDTH(32), .DEPTH(cff_pkg::PIEZO_ELEMENTS)) u_hp_ram (
    .clk(clk), .we(cmd.fin), .waddr(pi), .wdata(hp_res),
    .re(cmd.accept), .raddr(rd_pi), .rdata(hp_rd));
  cff_ram #(.WIDTH(32), .DEPTH(cff_pkg::PIEZO_ELEMENTS)) u_prev_ram (
    .clk(clk), .we(cmd.fin), .waddr(pi), .wdata(p_r),
    .re(cmd.accept), .raddr(rd_pi), .rdata(prev_rd));
  cff_ram #(.WIDTH(32), .DEPTH(cff_pkg::PIEZO_ELEMENTS)) u_held_ram (
    .clk(clk), .we(cmd.fin && code_nz_r), .waddr(pi), .wdata(capf_r),
    .re(cmd.accept), .raddr(rd_pi), .rdata(held_rd));
  cff_ram #(.WIDTH(32), .DEPTH(cff_pkg::CAP_ELEMENTS)) u_lp_ram (
    .clk(clk), .we(cmd.fin), .waddr(ci), .wdata(lp_res),
    .re(cmd.accept), .raddr(rd_ci), .rdata(lp_rd));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_vld_r   <= '0;
      held_vld_r <= '0;
      lp_vld_r   <= '0;
    end else if (cmd.fin) begin
      pv_vld_r[pi] <= 1'b1;
      lp_vld_r[ci] <= 1'b1;
      if (code_nz_r) held_vld_r[pi] <= 1'b1;
    end
  end

  logic signed [31:0] hp_old, prev_old, held_old, lp_old, p_val, capf_val;
  assign hp_old   = pv_hit_r   ? $signed(hp_rd)   : 32'sd0;
  assign prev_old = pv_hit_r   ? $signed(prev_rd) : 32'sd0;
  assign held_old = held_hit_r ? $signed(held_rd) : 32'sd0;
  assign lp_old   = lp_hit_r   ? $signed(lp_rd)   : 32'sd0;

  logic signed [63:0] p_rnd, c_rnd;
  assign p_rnd    = cff_pkg::round_sh(64'(pprod_r), cff_pkg::PIEZO_SHIFT);
  assign c_rnd    = cff_pkg::round_sh(64'(cprod_r), cff_pkg::CAP_SHIFT);
  assign p_val    = p_rnd[31:0];
  assign capf_val = code_nz_r ? cff_pkg::sat32(c_rnd) : held_old;

  assign hp_res = cff_pkg::sat32(cff_pkg::round_sh(64'(hprod_r), cff_pkg::COEFF_SHIFT));
  assign lp_res = cff_pkg::sat32(64'(lpold_r) +
                                 cff_pkg::round_sh(64'(lprod_r), cff_pkg::COEFF_SHIFT));

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      elem_r     <= in_element;
      code_nz_r  <= (in_cap_code != 24'sd0);
      m1_r       <= in_piezo_count * $signed({1'b0, in_piezo_gain});
      cm1_r      <= in_cap_code * $signed({1'b0, in_cap_gain});
      pv_hit_r   <= pv_vld_r[rd_pi];
      held_hit_r <= held_vld_r[rd_pi];
      lp_hit_r   <= lp_vld_r[rd_ci];
    end
    if (cmd.mul1) begin
      pprod_r <= m1_r * $signed(16'(cff_pkg::PIEZO_K));
      cprod_r <= cm1_r * $signed(20'(cff_pkg::CAP_K));
    end
    if (cmd.sum) begin
      p_r     <= p_val;
      hpsum_r <= 34'(hp_old) + 34'(p_val) - 34'(prev_old);
      capf_r  <= capf_val;
      diff_r  <= 33'(capf_val) - 33'(lp_old);
      lpold_r <= lp_old;
    end
    if (cmd.mul2) begin
      hprod_r <= hpsum_r * $signed({1'b0, hp_coeff_r});
      lprod_r <= diff_r * $signed({1'b0, lp_coeff_r});
    end
    if (cmd.fin) begin
      hpf_r <= hp_res;
      lpf_r <= lp_res;
    end
  end

  logic signed [32:0] fused, whole;
  logic signed [15:0] force_val;
  logic               clip_val;
  assign fused = 33'(hpf_r) + 33'(lpf_r);
  assign whole = fused[32] ? ((fused + 33'sd255) >>> 8) : (fused >>> 8);

  always_comb begin
    if (fused > 33'(cff_pkg::FORCE_LIMIT_Q8)) begin
      force_val = 16'(cff_pkg::FORCE_LIMIT);
      clip_val  = 1'b1;
    end else if (fused < -33'(cff_pkg::FORCE_LIMIT_Q8)) begin
      force_val = -16'(cff_pkg::FORCE_LIMIT);
      clip_val  = 1'b1;
    end else begin
      force_val = whole[15:0];
      clip_val  = 1'b0;
    end
  end

  logic out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_element <= elem_r;
      out_force   <= force_val;
      out_clipped <= clip_val;
    end
  end

  assign out_valid          = out_valid_r;
  assign status.out_blocked = out_valid_r && out_stall;

endmodule

// ===== hdl/complementary_force_fusion.sv =====
// Piezo / capacitive force fusion, one sensor element per request.
// Input channel (in_valid / in_stall): element index, piezo count, cap code
// and the two per-element gains. A request is taken on a clock edge with
// in_valid high and in_stall low.
// Output channel (out_valid / out_stall): echoed element, fused force in
// whole mN (saturated to +-32000) and a clip flag.
// Config port: cfg_we writes cfg_data into register cfg_index
// (0 = hp_coeff, 1 = lp_coeff); write only while no request is in flight.
// Each request walks the controller states MUL1, SUM, MUL2, FIN and OUT in
// order: the filter state memory read at accept, two multiply stages, the
// write-back in FIN and the output register load in OUT. in_stall stays high
// until the controller is back in IDLE, so one request is in flight at a time.
// A finished result sits in the output register; the block accepts the next
// request while it waits. If the receiver stalls, the next result waits in
// its last stage and in_stall stays high until the register frees up.
// Reset (synchronous, rst_n low) restores the default coefficients and marks
// all filter state as zero; no clearing pass is needed.
module complementary_force_fusion (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [5:0]         in_element,
  input  logic signed [11:0] in_piezo_count,
  input  logic signed [23:0] in_cap_code,
  input  logic [15:0]        in_piezo_gain,
  input  logic [15:0]        in_cap_gain,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         out_element,
  output logic signed [15:0] out_force,
  output logic               out_clipped,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [23:0]        cfg_data
);

  cff_pkg::cmd_t    cmd;
  cff_pkg::status_t status;

  cff_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .status(status), .cmd(cmd));

  cff_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_element(in_element), .in_piezo_count(in_piezo_count),
    .in_cap_code(in_cap_code), .in_piezo_gain(in_piezo_gain),
    .in_cap_gain(in_cap_gain),
    .out_valid(out_valid), .out_stall(out_stall), .out_element(out_element),
    .out_force(out_force), .out_clipped(out_clipped));

endmodule

// ===== bench/tb_complementary_force_fusion.sv =====
module tb_complementary_force_fusion;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [5:0]         el;
    logic signed [15:0] force_v;
    logic               clipped;
  } fused_t;

  class fusion_scoreboard;
    fused_t       fused_q[$];
    int           errors;
    logic [23:0]  hp_k;
    logic [23:0]  lp_k;
    int           hp_mem[cff_pkg::PIEZO_ELEMENTS];
    int           prev_mem[cff_pkg::PIEZO_ELEMENTS];
    int           held_mem[cff_pkg::PIEZO_ELEMENTS];
    int           lp_mem[cff_pkg::CAP_ELEMENTS];

    function new();
      errors = 0;
      hp_k = cff_pkg::HP_RESET;
      lp_k = cff_pkg::LP_RESET;
      foreach (hp_mem[i]) begin
        hp_mem[i] = 0;
        prev_mem[i] = 0;
        held_mem[i] = 0;
      end
      foreach (lp_mem[i]) lp_mem[i] = 0;
    endfunction

    // nearest, halves away from zero
    function longint rnd_shift(longint v, int n);
      longint half;
      half = 64'sd1 <<< (n - 1);
      if (v >= 0) return (v + half) >>> n;
      return -((-v + half) >>> n);
    endfunction

    function int clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
    endfunction

    function void set_coeff(logic idx, logic [23:0] v);
      if (idx == cff_pkg::REG_HP_COEFF) hp_k = v;
      else lp_k = v;
    endfunction

    function void note_request(logic [5:0] el, logic signed [11:0] cnt,
                               logic signed [23:0] code, logic [15:0] pg,
                               logic [15:0] cg);
      int     pi;
      int     ci;
      longint p;
      longint hp;
      longint capf;
      longint lp;
      longint fused;
      fused_t r;
      pi = el % cff_pkg::PIEZO_ELEMENTS;
      ci = (el / 2) % cff_pkg::CAP_ELEMENTS;
      p = rnd_shift(longint'(cnt) * longint'(pg) * cff_pkg::PIEZO_K, cff_pkg::PIEZO_SHIFT);
      hp = longint'(hp_mem[pi]) + p - longint'(prev_mem[pi]);
      hp = clamp32(rnd_shift(hp * longint'(hp_k), cff_pkg::COEFF_SHIFT));
      hp_mem[pi] = int'(hp);
      prev_mem[pi] = int'(p);
      if (code != 0)
        held_mem[pi] = clamp32(rnd_shift(longint'(code) * longint'(cg) * cff_pkg::CAP_K,
                                         cff_pkg::CAP_SHIFT));
      capf = held_mem[pi];
      lp = lp_mem[ci];
      lp = clamp32(lp + rnd_shift((capf - lp) * longint'(lp_k), cff_pkg::COEFF_SHIFT));
      lp_mem[ci] = int'(lp);
      fused = lp + hp;
      r.el = el;
      r.clipped = 1'b1;
      if (fused > cff_pkg::FORCE_LIMIT_Q8) r.force_v = 16'(cff_pkg::FORCE_LIMIT);
      else if (fused < -cff_pkg::FORCE_LIMIT_Q8) r.force_v = 16'(-cff_pkg::FORCE_LIMIT);
      else begin
        r.force_v = 16'(fused / 256);
        r.clipped = 1'b0;
      end
      fused_q.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_result(logic [5:0] el, logic signed [15:0] f, logic c);
      fused_t e;
      if (fused_q.size() == 0) begin
        report($sformatf("unexpected result el=%0d force=%0d", el, f));
        return;
      end
      e = fused_q.pop_front();
      if (el !== e.el) report($sformatf("element %0d, want %0d", el, e.el));
      if (f !== e.force_v)
        report($sformatf("el %0d force %0d, want %0d", e.el, f, e.force_v));
      if (c !== e.clipped)
        report($sformatf("el %0d clipped %0b, want %0b", e.el, c, e.clipped));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [5:0]         in_element = '0;
  logic signed [11:0] in_piezo_count = '0;
  logic signed [23:0] in_cap_code = '0;
  logic [15:0]        in_piezo_gain = '0;
  logic [15:0]        in_cap_gain = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [5:0]         out_element;
  logic signed [15:0] out_force;
  logic               out_clipped;
  logic               cfg_we = 1'b0;
  logic               cfg_index = cff_pkg::REG_HP_COEFF;
  logic [23:0]        cfg_data = '0;

  fusion_scoreboard sb = new();
  bit  hold_req = 0;
  bit  no_idle = 0;
  int  cycles = 0;

  complementary_force_fusion DUT (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && !out_stall) sb.check_result(out_element, out_force, out_clipped);

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  // receiver: random stalls, plus one long hold-off when asked
  initial begin
    int s;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_req = 0;
      end else begin
        s = pick_gap();
        if (s > 0) begin
          out_stall <= 1'b1;
          repeat (s) @(posedge clk);
        end
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  task automatic send(logic [5:0] el, logic [11:0] cnt, logic [23:0] code,
                      logic [15:0] pg, logic [15:0] cg);
    int g;
    in_valid <= 1'b1;
    in_element <= el;
    in_piezo_count <= cnt;
    in_cap_code <= code;
    in_piezo_gain <= pg;
    in_cap_gain <= cg;
    do @(posedge clk); while (in_stall);
    sb.note_request(el, cnt, code, pg, cg);
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.fused_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_coeff(logic idx, logic [23:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_coeff(idx, v);
  endtask

  function automatic logic [15:0] rand_gain();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return 16'h1000;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_random();
    logic [11:0] cnt;
    logic [23:0] code;
    case ($urandom_range(0, 9))
      0: cnt = 12'h800;
      1: cnt = 12'h7FF;
      default: cnt = 12'($urandom());
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2: code = '0;
      3: code = 24'h800000;
      4: code = 24'h7FFFFF;
      5: code = 24'($urandom_range(1, 2000));
      default: code = 24'($urandom());
    endcase
    send(6'($urandom()), cnt, code, rand_gain(), rand_gain());
  endtask

  initial begin
    logic [23:0] hp_set[5];
    logic [23:0] lp_set[5];
    hp_set = '{cff_pkg::HP_RESET, 24'h000000, 24'hFFFFFF, 24'h000000, 24'h800000};
    lp_set = '{cff_pkg::LP_RESET, 24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'h000001};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, held cap reuse, shared low-pass pair, saturation
    send(6'd0, 12'h7FF, 24'h7FFFFF, 16'hFFFF, 16'hFFFF);
    send(6'd0, 12'h800, 24'h000000, 16'hFFFF, 16'hFFFF);
    send(6'd0, 12'h000, 24'h000000, 16'h0000, 16'h0000);
    send(6'd63, 12'h800, 24'h800000, 16'hFFFF, 16'hFFFF);
    send(6'd62, 12'h7FF, 24'h000000, 16'hFFFF, 16'h0000);
    send(6'd63, 12'h001, 24'h000000, 16'h1000, 16'h1000);
    send(6'd2, 12'h100, 24'h001000, 16'h1000, 16'h1000);
    send(6'd3, 12'h000, 24'h000000, 16'h1000, 16'h1000);
    send(6'd2, 12'h000, 24'h000000, 16'h1000, 16'h1000);
    send(6'd3, 12'hF00, 24'hFFF000, 16'h2000, 16'h2000);
    send(6'd5, 12'h7FF, 24'h7FFFFF, 16'hFFFF, 16'h0100);
    send(6'd5, 12'h7FF, 24'h000000, 16'hFFFF, 16'h0100);
    send(6'd6, 12'h000, 24'h000001, 16'h0000, 16'h0001);
    send(6'd7, 12'hFFF, 24'hFFFFFF, 16'h0001, 16'hFFFF);
    send(6'd42, 12'h555, 24'h555555, 16'hAAAA, 16'h5555);
    send(6'd21, 12'hAAA, 24'hAAAAAA, 16'h5555, 16'hAAAA);

    // long receiver hold-off while requests keep coming
    hold_req = 1;
    repeat (24) send_random();
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_coeff(cff_pkg::REG_HP_COEFF, hp_set[ph]);
      write_coeff(cff_pkg::REG_LP_COEFF, lp_set[ph]);
      no_idle = (ph == 2);
      for (int i = 0; i < 310; i++) begin
        send_random();
        // sender waits for everything to come back once
        if (ph == 1 && i == 150) drain();
      end
      drain();
    end
    no_idle = 0;
    repeat (20) @(posedge clk);

    if (sb.errors == 0 && sb.fused_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
